FILE: rtl/core/pidpom_pkg.sv
// pidpom_pkg: shared types, codes and constants of the PID controller.
// No dependencies; imported by every module of the block.

package pidpom_pkg;

  // Fixed field widths
  localparam int LIMIT_W    = 16;  // out_min / out_max
  localparam int SETPT_W    = 16;  // setpoint
  localparam int GAIN_W     = 24;  // unsigned gains
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Parameter defaults
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 12;

  // Register reset values
  localparam logic [LIMIT_W-1:0] OUT_MIN_RST = 16'h8000;
  localparam logic [LIMIT_W-1:0] OUT_MAX_RST = 16'h7FFF;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_STOP   = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT = 4'd0,
    CFG_KP_GAIN  = 4'd1,
    CFG_KI_GAIN  = 4'd2,
    CFG_KD_GAIN  = 4'd3,
    CFG_OUT_MIN  = 4'd4,
    CFG_OUT_MAX  = 4'd5,
    CFG_P_ON_ERR = 4'd6,
    CFG_REVERSE  = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [SETPT_W-1:0] setpoint;
    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  ki_gain;
    logic [GAIN_W-1:0]  kd_gain;
    logic [LIMIT_W-1:0] out_min;
    logic [LIMIT_W-1:0] out_max;
    logic               p_on_error;
    logic               reverse;
  } cfg_t;

endpackage

FILE: rtl/core/pid_controller_pom.sv
// Pipeline: an accepted request passes through the input register, the term
//   register and the result register, then out_valid rises. Throughput: one
//   request per cycle while the result is not stalled; the integral and previous
//   sample are updated in the term stage, so a request may follow in the very
//   next cycle. Each stage holds under stall.
// Reset (rst_n low, synchronous): pipeline emptied, controller stopped,
//   history cleared, registers back to their reset values.

module pid_controller_pom import pidpom_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_func,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_drive,
  output logic                           out_running
);

  localparam int MW = ((SAMPLE_WIDTH > SETPT_W) ? SAMPLE_WIDTH : SETPT_W) + 1;
  localparam int PW = MW + GAIN_W + 1;
  localparam int AW = PW + 2;
  localparam int IW = LIMIT_W + FRAC_BITS;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC_BITS - 1);

  // ---------------- configuration registers ----------------
  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint   <= '0;
      cfg_r.kp_gain    <= '0;
      cfg_r.ki_gain    <= '0;
      cfg_r.kd_gain    <= '0;
      cfg_r.out_min    <= OUT_MIN_RST;
      cfg_r.out_max    <= OUT_MAX_RST;
      cfg_r.p_on_error <= 1'b0;
      cfg_r.reverse    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SETPOINT: cfg_r.setpoint   <= cfg_data[SETPT_W-1:0];
        CFG_KP_GAIN:  cfg_r.kp_gain    <= cfg_data[GAIN_W-1:0];
        CFG_KI_GAIN:  cfg_r.ki_gain    <= cfg_data[GAIN_W-1:0];
        CFG_KD_GAIN:  cfg_r.kd_gain    <= cfg_data[GAIN_W-1:0];
        CFG_OUT_MIN:  cfg_r.out_min    <= cfg_data[LIMIT_W-1:0];
        CFG_OUT_MAX:  cfg_r.out_max    <= cfg_data[LIMIT_W-1:0];
        CFG_P_ON_ERR: cfg_r.p_on_error <= cfg_data[0];
        CFG_REVERSE:  cfg_r.reverse    <= cfg_data[0];
        default: ;    // unmapped index: dropped
      endcase
    end
  end

  // ---------------- stage handshake ----------------
  // Each stage loads when empty or when it empties into the next one.
  logic s0_v_r;
  logic s1_v_r;
  logic out_valid_r;
  logic s0_rdy;
  logic s1_rdy;
  logic s2_rdy;
  logic s0_go;   // s0 moves into s1 this cycle

  assign s2_rdy   = !out_valid_r || out_ready;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign s0_rdy   = !s0_v_r || s1_rdy;
  assign in_ready = s0_rdy;
  assign s0_go    = s0_v_r && s1_rdy;

  // ---------------- stage 0: input register ----------------
  logic [1:0]                     s0_func_r;
  logic signed [SAMPLE_WIDTH-1:0] s0_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s0_rdy) begin
      s0_func_r   <= in_func;
      s0_sample_r <= in_sample;
    end
  end

  // ---------------- controller state and term stage ----------------
  logic signed [SAMPLE_WIDTH-1:0] prev_r;
  logic signed [SAMPLE_WIDTH-1:0] prev_nxt;
  logic signed [IW-1:0]           integ_r;
  logic signed [IW-1:0]           integ_nxt;
  logic                           run_r;
  logic                           run_nxt;
  logic                           act_nxt;   // sample taken while running

  logic signed [IW-1:0] integ_upd;
  logic signed [PW-1:0] pterm;
  logic signed [PW-1:0] dterm;

  pidpom_update #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_update (
    .cfg         (cfg_r),
    .sample      (s0_sample_r),
    .prev_sample (prev_r),
    .integ       (integ_r),
    .integ_nxt   (integ_upd),
    .pterm       (pterm),
    .dterm       (dterm)
  );

  always_comb begin
    prev_nxt  = prev_r;
    integ_nxt = integ_r;
    run_nxt   = run_r;
    act_nxt   = 1'b0;
    case (s0_func_r)
      FUNC_START: begin
        prev_nxt  = '0;
        integ_nxt = '0;
        run_nxt   = 1'b1;
      end
      FUNC_STOP: begin
        run_nxt = 1'b0;
      end
      FUNC_SAMPLE: begin
        // a sample while stopped leaves the history alone
        if (run_r) begin
          prev_nxt  = s0_sample_r;
          integ_nxt = integ_upd;
          act_nxt   = 1'b1;
        end
      end
      default: ;    // unused code: no effect
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
      run_r   <= 1'b0;
    end else if (s0_go) begin
      prev_r  <= prev_nxt;
      integ_r <= integ_nxt;
      run_r   <= run_nxt;
    end
  end

  // stage 1 registers: terms for the drive sum
  logic                 s1_act_r;
  logic                 s1_run_r;
  logic signed [IW-1:0] s1_integ_r;
  logic signed [PW-1:0] s1_pterm_r;
  logic signed [PW-1:0] s1_dterm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go) begin
      s1_act_r   <= act_nxt;
      s1_run_r   <= run_nxt;
      s1_integ_r <= integ_nxt;
      s1_pterm_r <= pterm;
      s1_dterm_r <= dterm;
    end
  end

  // ---------------- stage 2: drive sum, clamp, round ----------------
  logic signed [AW-1:0]           sum_w;
  logic signed [AW-1:0]           lo_w;
  logic signed [AW-1:0]           hi_w;
  logic signed [AW-1:0]           sum_c;
  logic signed [AW-1:0]           rnd_w;
  logic signed [SAMPLE_WIDTH-1:0] drive_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_drive_r;
  logic                           out_running_r;

  assign sum_w = AW'(s1_pterm_r) + AW'(s1_integ_r) - AW'(s1_dterm_r);
  assign lo_w  = AW'($signed(cfg_r.out_min)) <<< FRAC_BITS;
  assign hi_w  = AW'($signed(cfg_r.out_max)) <<< FRAC_BITS;

  always_comb begin
    if (sum_w < lo_w) begin
      sum_c = lo_w;
    end else if (sum_w > hi_w) begin
      sum_c = hi_w;
    end else begin
      sum_c = sum_w;
    end
  end

  // round half up; limits are whole numbers so the result stays in range
  assign rnd_w     = (sum_c + HALF) >>> FRAC_BITS;
  assign drive_nxt = s1_act_r ? rnd_w[SAMPLE_WIDTH-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_rdy) begin
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_rdy) begin
      out_drive_r   <= drive_nxt;
      out_running_r <= s1_run_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drive   = out_drive_r;
  assign out_running = out_running_r;

endmodule

FILE: rtl/core/pidpom_update.sv
// pidpom_update: first datapath stage - error/delta, gain products and the
// clamped integral update. Purely combinational. Depends on pidpom_pkg.

module pidpom_update import pidpom_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  localparam int MW = ((SAMPLE_WIDTH > SETPT_W) ? SAMPLE_WIDTH : SETPT_W) + 1,
  localparam int PW = MW + GAIN_W + 1,
  localparam int AW = PW + 2,
  localparam int IW = LIMIT_W + FRAC_BITS
) (
  input  cfg_t                           cfg,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_sample,
  input  logic signed [IW-1:0]           integ,
  output logic signed [IW-1:0]           integ_nxt,
  output logic signed [PW-1:0]           pterm,
  output logic signed [PW-1:0]           dterm
);

  localparam int GW = GAIN_W + 1;

  logic signed [MW-1:0] err_w;
  logic signed [MW-1:0] dlt_w;
  logic signed [MW-1:0] kp_op;
  logic signed [GW-1:0] kp_s;
  logic signed [GW-1:0] ki_s;
  logic signed [GW-1:0] kd_s;
  logic signed [PW-1:0] kp_prod;
  logic signed [PW-1:0] ki_prod;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] lo_w;
  logic signed [AW-1:0] hi_w;
  logic signed [AW-1:0] acc_c;

  assign err_w = MW'($signed(cfg.setpoint)) - MW'(sample);
  assign dlt_w = MW'(sample) - MW'(prev_sample);

  // reverse acting: negate gains
  assign kp_s = cfg.reverse ? -$signed({1'b0, cfg.kp_gain}) : $signed({1'b0, cfg.kp_gain});
  assign ki_s = cfg.reverse ? -$signed({1'b0, cfg.ki_gain}) : $signed({1'b0, cfg.ki_gain});
  assign kd_s = cfg.reverse ? -$signed({1'b0, cfg.kd_gain}) : $signed({1'b0, cfg.kd_gain});

  // kp acts on error or on measurement, never both: one multiplier
  assign kp_op   = cfg.p_on_error ? err_w : dlt_w;
  assign kp_prod = PW'(kp_op) * PW'(kp_s);
  assign ki_prod = PW'(err_w) * PW'(ki_s);
  assign dterm   = PW'(dlt_w) * PW'(kd_s);
  assign pterm   = cfg.p_on_error ? kp_prod : '0;

  assign lo_w = AW'($signed(cfg.out_min)) <<< FRAC_BITS;
  assign hi_w = AW'($signed(cfg.out_max)) <<< FRAC_BITS;

  assign acc = AW'(integ) + AW'(ki_prod) - (cfg.p_on_error ? '0 : AW'(kp_prod));

  // crossed limits: a value below the low bound takes the low bound, any other the high bound
  always_comb begin
    if (acc < lo_w) begin
      acc_c = lo_w;
    end else if (acc > hi_w) begin
      acc_c = hi_w;
    end else begin
      acc_c = acc;
    end
  end

  // clamped value always fits the limit range
  assign integ_nxt = acc_c[IW-1:0];

endmodule

FILE: rtl/core/pidpom_checker.sv
// pidpom_checker: port-level assertions for pid_controller_pom, plus the
// bind that attaches it. Depends on pidpom_pkg and pid_controller_pom.

module pidpom_checker import pidpom_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] out_drive,
  input logic                           out_running
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_running))
    else $error("result changed under stall");

  // a stopped controller never drives
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running |-> out_drive == '0)
    else $error("nonzero drive while stopped");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // back-pressure only comes from a stalled result
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request blocked without output stall");

endmodule

bind pid_controller_pom pidpom_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_pidpom_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_drive   (out_drive),
  .out_running (out_running)
);
